// File: rtl/fsfc_pkg.sv
package fsfc_pkg;

    localparam int ADDR_W = 24;
    localparam int DATA_W = 64;

    localparam logic [ADDR_W-1:0] REGION_BASE_RESET = 24'd12288;

    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_POLL = 2'd1;
    localparam logic [1:0] REQ_FILL = 2'd2;

    localparam logic [2:0] KIND_SEND     = 3'd0;
    localparam logic [2:0] KIND_WR_CMD   = 3'd1;
    localparam logic [2:0] KIND_RD_CMD   = 3'd2;
    localparam logic [2:0] KIND_ERASE    = 3'd3;
    localparam logic [2:0] KIND_WR_DATA  = 3'd4;
    localparam logic [2:0] KIND_EMPTY    = 3'd5;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [DATA_W-1:0] sample_low;
        logic [DATA_W-1:0] sample_high;
        logic [3:0]        fill_index;
    } req_t;

    typedef struct packed {
        logic [2:0]        result_kind;
        logic [ADDR_W-1:0] flash_address;
        logic [DATA_W-1:0] item_low;
        logic [DATA_W-1:0] item_high;
        logic              last;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FLUSH = 3'b010,
        ST_ERASE = 3'b100
    } state_t;

endpackage

// File: rtl/flash_spill_fifo_controller_unit.sv
// Flash-backed circular log controller. An item is taken when start is high and busy is low;
// every result appears on result for exactly one cycle with result_valid high and cannot be
// held off, so the receiver must take each beat as it comes. The push that fills the staging
// buffer makes the block busy in ST_FLUSH while the write command goes out and the staged
// records are read out of the staging memory (one read port, one record per cycle). A poll
// gives its result in the next cycle; when a sector erase command follows, the block is busy
// in ST_ERASE until it is issued. A fill gives no result. Results are registered.
module flash_spill_fifo_controller_unit #(
    parameter int ITEMS_PER_BLOCK   = 16,
    parameter int BLOCKS_PER_SECTOR = 16,
    parameter int SECTOR_COUNT      = 2,
    parameter int BLOCK_BYTES       = 256,
    parameter int SECTOR_BYTES      = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  fsfc_pkg::req_t                       req,
    output logic                                 result_valid,
    output fsfc_pkg::res_t                       result,
    input  logic                                 cfg_we,
    input  logic [fsfc_pkg::ADDR_W-1:0]          cfg_wdata
);
    import fsfc_pkg::*;

    localparam int ITEM_W = $clog2(ITEMS_PER_BLOCK);
    localparam int BLK_W  = (BLOCKS_PER_SECTOR > 1) ? $clog2(BLOCKS_PER_SECTOR) : 1;
    localparam int SEC_W  = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
    localparam int TOTAL  = ITEMS_PER_BLOCK * BLOCKS_PER_SECTOR * SECTOR_COUNT;
    localparam int LIN_W  = $clog2(TOTAL);

    localparam logic [ITEM_W-1:0] ITEM_LAST = ITEM_W'(ITEMS_PER_BLOCK - 1);
    localparam logic [BLK_W-1:0]  BLK_LAST  = BLK_W'(BLOCKS_PER_SECTOR - 1);
    localparam logic [SEC_W-1:0]  SEC_LAST  = SEC_W'(SECTOR_COUNT - 1);
    localparam logic [LIN_W-1:0]  LIN_LAST  = LIN_W'(TOTAL - 1);

    // record memories
    logic [2*DATA_W-1:0] stage_mem [ITEMS_PER_BLOCK];
    logic [2*DATA_W-1:0] rx_mem    [ITEMS_PER_BLOCK];
    logic [2*DATA_W-1:0] stage_q;
    logic [2*DATA_W-1:0] rx_q;

    logic                stage_we;
    logic                stage_re;
    logic [ITEM_W-1:0]   stage_raddr;
    logic                rx_we;
    logic [ITEM_W-1:0]   rx_waddr;
    logic                rx_re;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   base_reg;
    logic [ITEM_W-1:0]   wr_item_reg, wr_item_next;
    logic [BLK_W-1:0]    wr_block_reg, wr_block_next;
    logic [SEC_W-1:0]    wr_sector_reg, wr_sector_next;
    logic [ITEM_W-1:0]   rd_item_reg, rd_item_next;
    logic [BLK_W-1:0]    rd_block_reg, rd_block_next;
    logic [SEC_W-1:0]    rd_sector_reg, rd_sector_next;
    logic                rx_loaded_reg, rx_loaded_next;
    logic [LIN_W-1:0]    wr_lin_reg, wr_lin_next;
    logic [LIN_W-1:0]    rd_lin_reg, rd_lin_next;
    logic [ITEM_W-1:0]   flush_cnt_reg, flush_cnt_next;
    logic [ADDR_W-1:0]   erase_addr_reg, erase_addr_next;

    logic                valid_reg, valid_next;
    logic [2:0]          kind_reg, kind_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                last_reg, last_next;
    logic                data_en_reg, data_en_next;
    logic                src_rx_reg, src_rx_next;

    logic                accept;
    logic [LIN_W:0]      span;
    logic                send_now;

    function automatic logic [ADDR_W-1:0] blk_addr(input logic [SEC_W-1:0] s,
                                                   input logic [BLK_W-1:0] b);
        blk_addr = base_reg + ADDR_W'(s) * ADDR_W'(SECTOR_BYTES)
                 + ADDR_W'(b) * ADDR_W'(BLOCK_BYTES);
    endfunction

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // write minus read, modulo ring size
    always_comb
    begin
        if (wr_lin_reg >= rd_lin_reg)
        begin
            span = {1'b0, wr_lin_reg} - {1'b0, rd_lin_reg};
        end
        else
        begin
            span = {1'b0, wr_lin_reg} + (LIN_W + 1)'(TOTAL) - {1'b0, rd_lin_reg};
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        wr_item_next    = wr_item_reg;
        wr_block_next   = wr_block_reg;
        wr_sector_next  = wr_sector_reg;
        rd_item_next    = rd_item_reg;
        rd_block_next   = rd_block_reg;
        rd_sector_next  = rd_sector_reg;
        rx_loaded_next  = rx_loaded_reg;
        wr_lin_next     = wr_lin_reg;
        rd_lin_next     = rd_lin_reg;
        flush_cnt_next  = flush_cnt_reg;
        erase_addr_next = erase_addr_reg;
        valid_next      = 1'b0;
        kind_next       = kind_reg;
        addr_next       = addr_reg;
        last_next       = last_reg;
        data_en_next    = data_en_reg;
        src_rx_next     = src_rx_reg;
        stage_we        = 1'b0;
        stage_re        = 1'b0;
        stage_raddr     = rd_item_reg;
        rx_we           = 1'b0;
        rx_waddr        = ITEM_W'(req.fill_index);
        rx_re           = 1'b0;
        send_now        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        REQ_PUSH:
                        begin
                            stage_we     = 1'b1;
                            wr_lin_next  = (wr_lin_reg == LIN_LAST) ? '0 : wr_lin_reg + 1'b1;
                            wr_item_next = (wr_item_reg == ITEM_LAST) ? '0 : wr_item_reg + 1'b1;
                            if (wr_item_reg == ITEM_LAST)
                            begin
                                valid_next     = 1'b1;
                                kind_next      = KIND_WR_CMD;
                                addr_next      = blk_addr(wr_sector_reg, wr_block_reg);
                                last_next      = 1'b0;
                                data_en_next   = 1'b0;
                                flush_cnt_next = '0;
                                state_next     = ST_FLUSH;
                                wr_block_next  = (wr_block_reg == BLK_LAST) ? '0
                                               : wr_block_reg + 1'b1;
                                if (wr_block_reg == BLK_LAST)
                                begin
                                    wr_sector_next = (wr_sector_reg == SEC_LAST) ? '0
                                                   : wr_sector_reg + 1'b1;
                                end
                            end
                        end
                        REQ_POLL:
                        begin
                            valid_next   = 1'b1;
                            addr_next    = '0;
                            last_next    = 1'b1;
                            data_en_next = 1'b0;
                            if (rx_loaded_reg)
                            begin
                                rx_re        = 1'b1;
                                src_rx_next  = 1'b1;
                                send_now     = 1'b1;
                            end
                            else if (span >= (LIN_W + 1)'(ITEMS_PER_BLOCK))
                            begin
                                kind_next      = KIND_RD_CMD;
                                addr_next      = blk_addr(rd_sector_reg, rd_block_reg);
                                rx_loaded_next = 1'b1;
                            end
                            else if (span != '0)
                            begin
                                stage_re    = 1'b1;
                                src_rx_next = 1'b0;
                                send_now    = 1'b1;
                            end
                            else
                            begin
                                kind_next = KIND_EMPTY;
                            end
                            if (send_now)
                            begin
                                kind_next    = KIND_SEND;
                                data_en_next = 1'b1;
                                rd_lin_next  = (rd_lin_reg == LIN_LAST) ? '0 : rd_lin_reg + 1'b1;
                                rd_item_next = (rd_item_reg == ITEM_LAST) ? '0
                                             : rd_item_reg + 1'b1;
                                if (rd_item_reg == ITEM_LAST)
                                begin
                                    rx_loaded_next = 1'b0;
                                    rd_block_next  = (rd_block_reg == BLK_LAST) ? '0
                                                   : rd_block_reg + 1'b1;
                                    if (rd_block_reg == BLK_LAST)
                                    begin
                                        // sector finished, erase follows
                                        last_next       = 1'b0;
                                        erase_addr_next = blk_addr(rd_sector_reg, '0);
                                        state_next      = ST_ERASE;
                                        rd_sector_next  = (rd_sector_reg == SEC_LAST) ? '0
                                                        : rd_sector_reg + 1'b1;
                                    end
                                end
                            end
                        end
                        REQ_FILL:
                        begin
                            rx_we = (32'(req.fill_index) < 32'(ITEMS_PER_BLOCK));
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FLUSH:
            begin
                stage_re     = 1'b1;
                stage_raddr  = flush_cnt_reg;
                src_rx_next  = 1'b0;
                valid_next   = 1'b1;
                kind_next    = KIND_WR_DATA;
                addr_next    = '0;
                data_en_next = 1'b1;
                last_next    = (flush_cnt_reg == ITEM_LAST);
                if (flush_cnt_reg == ITEM_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    flush_cnt_next = flush_cnt_reg + 1'b1;
                end
            end
            ST_ERASE:
            begin
                valid_next   = 1'b1;
                kind_next    = KIND_ERASE;
                addr_next    = erase_addr_reg;
                data_en_next = 1'b0;
                last_next    = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_we)
        begin
            stage_mem[wr_item_reg] <= {req.sample_high, req.sample_low};
        end
        if (stage_re)
        begin
            stage_q <= stage_mem[stage_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_we)
        begin
            rx_mem[rx_waddr] <= {req.sample_high, req.sample_low};
        end
        if (rx_re)
        begin
            rx_q <= rx_mem[rd_item_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= REGION_BASE_RESET;
            wr_item_reg   <= '0;
            wr_block_reg  <= '0;
            wr_sector_reg <= '0;
            rd_item_reg   <= '0;
            rd_block_reg  <= '0;
            rd_sector_reg <= '0;
            rx_loaded_reg <= 1'b0;
            wr_lin_reg    <= '0;
            rd_lin_reg    <= '0;
            flush_cnt_reg <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            wr_item_reg   <= wr_item_next;
            wr_block_reg  <= wr_block_next;
            wr_sector_reg <= wr_sector_next;
            rd_item_reg   <= rd_item_next;
            rd_block_reg  <= rd_block_next;
            rd_sector_reg <= rd_sector_next;
            rx_loaded_reg <= rx_loaded_next;
            wr_lin_reg    <= wr_lin_next;
            rd_lin_reg    <= rd_lin_next;
            flush_cnt_reg <= flush_cnt_next;
            valid_reg     <= valid_next;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        erase_addr_reg <= erase_addr_next;
        kind_reg       <= kind_next;
        addr_reg       <= addr_next;
        last_reg       <= last_next;
        data_en_reg    <= data_en_next;
        src_rx_reg     <= src_rx_next;
    end

    always_comb
    begin
        result.result_kind   = kind_reg;
        result.flash_address = addr_reg;
        result.last          = last_reg;
        if (!data_en_reg)
        begin
            result.item_low  = '0;
            result.item_high = '0;
        end
        else if (src_rx_reg)
        begin
            result.item_low  = rx_q[DATA_W-1:0];
            result.item_high = rx_q[2*DATA_W-1:DATA_W];
        end
        else
        begin
            result.item_low  = stage_q[DATA_W-1:0];
            result.item_high = stage_q[2*DATA_W-1:DATA_W];
        end
    end

    assign result_valid = valid_reg;

endmodule
